@@ src/lkt_pkg.sv @@
package lkt_pkg;

	localparam int CAPACITY = 4;
	localparam int KEY_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OCC_W = 3;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [OCC_W-1:0] occ_t;

	// carried from each cell to the next one toward the least recent end
	typedef struct packed {
		logic hit;
		key_t key;
	} link_t;

endpackage

@@ src/lkt_req_if.sv @@
interface lkt_req_if
	import lkt_pkg::*;
();
	logic valid;
	logic ready;
	key_t request_key;

	modport source (output valid, output request_key, input ready);
	modport sink (input valid, input request_key, output ready);
endinterface

@@ src/lkt_rsp_if.sv @@
interface lkt_rsp_if
	import lkt_pkg::*;
();
	logic valid;
	logic ready;
	logic hit;
	logic evicted;
	key_t evicted_key;
	occ_t occupancy;

	modport source (output valid, output hit, output evicted, output evicted_key,
		output occupancy, input ready);
	modport sink (input valid, input hit, input evicted, input evicted_key,
		input occupancy, output ready);
endinterface

@@ src/lkt_cell.sv @@
module lkt_cell
	import lkt_pkg::*;
(
	input  logic  clk,
	input  logic  advance,
	input  logic  live,
	input  key_t  request_key,
	input  link_t link_in,
	output link_t link_out
);

	key_t key_q;
	logic match;

	assign match = live && (key_q == request_key);

	assign link_out.hit = link_in.hit | match;
	assign link_out.key = key_q;

	// take the neighbor's key unless a more recent cell already matched
	always_ff @(posedge clk) begin
		if (advance && !link_in.hit) begin
			key_q <= link_in.key;
		end
	end

endmodule

@@ src/lru_key_tracker.sv @@
// LRU key tracker: holds up to CAPACITY 32-bit keys ordered from most to least
// recently used, in a row of cells, each holding one key. Each request compares
// its key against all held keys at once; on a hit the key moves to the front,
// on a miss it is inserted at the front and, with the row full, the key in the
// last cell is evicted and reported. One request is taken every cycle unless
// an untaken response waits; the response appears on the next cycle from an
// output register, and a new request is taken while that response waits as
// long as it is being taken in the same cycle. The per-cycle work is bounded
// by the hit chain through all CAPACITY cells. The store is empty after reset.
module lru_key_tracker
	import lkt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	lkt_req_if.sink req,
	lkt_rsp_if.source rsp
);

	link_t chain [CAPACITY+1];
	logic  accept;
	logic  full;
	logic  miss_hit;
	cnt_t  count_q;
	cnt_t  count_next;

	logic rsp_valid_q;
	logic hit_q;
	logic evicted_q;
	key_t evicted_key_q;
	occ_t occupancy_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;
	assign full = (count_q == cnt_t'(CAPACITY));

	assign chain[0].hit = 1'b0;
	assign chain[0].key = req.request_key;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lkt_cell u_cell (
			.clk         (clk),
			.advance     (accept),
			.live        (cnt_t'(i) < count_q),
			.request_key (req.request_key),
			.link_in     (chain[i]),
			.link_out    (chain[i+1])
		);
	end

	assign miss_hit = chain[CAPACITY].hit;

	always_comb begin
		count_next = count_q;
		if (!miss_hit && !full) begin
			count_next = count_q + cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the response until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q <= miss_hit;
			evicted_q <= !miss_hit && full;
			evicted_key_q <= (!miss_hit && full) ? chain[CAPACITY].key : '0;
			occupancy_q <= occ_t'(count_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.hit = hit_q;
	assign rsp.evicted = evicted_q;
	assign rsp.evicted_key = evicted_key_q;
	assign rsp.occupancy = occupancy_q;

endmodule

@@ dv/tb_lru_key_tracker.sv @@
module tb_lru_key_tracker;
	import lkt_pkg::*;

	typedef struct packed {
		logic hit;
		logic evicted;
		key_t evicted_key;
		occ_t occupancy;
	} lru_result_t;

	bit clk;
	logic arst_n = 1'b0;

	lkt_req_if req_ch();
	lkt_rsp_if rsp_ch();

	lru_key_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	key_t requests_to_send[$];
	lru_result_t pending_responses[$];

	key_t held_keys[CAPACITY];
	int held_count;

	bit req_taken;
	int send_gap;
	int ready_stall;
	int mismatches;

	function automatic lru_result_t lru_lookup(key_t key);
		lru_result_t r;
		int pos;
		r = '0;
		pos = -1;
		for (int i = 0; i < held_count; i++) begin
			if (pos < 0 && held_keys[i] == key)
				pos = i;
		end
		if (pos >= 0) begin
			r.hit = 1'b1;
			for (int i = pos; i > 0; i--)
				held_keys[i] = held_keys[i-1];
			held_keys[0] = key;
		end else begin
			if (held_count >= CAPACITY) begin
				r.evicted = 1'b1;
				r.evicted_key = held_keys[CAPACITY-1];
				held_count = CAPACITY - 1;
			end
			for (int i = held_count; i > 0; i--)
				held_keys[i] = held_keys[i-1];
			held_keys[0] = key;
			held_count++;
		end
		r.occupancy = occ_t'(held_count);
		return r;
	endfunction

	function automatic void queue_request(key_t key);
		requests_to_send = {requests_to_send, key};
	endfunction

	function automatic bit calm_tail();
		return requests_to_send.size() <= 100;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (requests_to_send.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (!calm_tail() && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 9);
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid <= 1'b1;
				req_ch.request_key <= requests_to_send.pop_front();
			end
		end
	end

	// response backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (ready_stall > 0) begin
			ready_stall--;
			rsp_ch.ready <= 1'b0;
		end else if (!calm_tail() && $urandom_range(0, 7) == 0) begin
			ready_stall = $urandom_range(0, 9);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// monitor: check responses, then predict for the request taken at this edge
	always @(posedge clk) begin
		lru_result_t want;
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: hit=%0b evicted=%0b key=%h occ=%0d",
						rsp_ch.hit, rsp_ch.evicted, rsp_ch.evicted_key, rsp_ch.occupancy);
			end else begin
				want = pending_responses.pop_front();
				if (rsp_ch.hit !== want.hit || rsp_ch.evicted !== want.evicted ||
						rsp_ch.evicted_key !== want.evicted_key ||
						rsp_ch.occupancy !== want.occupancy) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("response mismatch: expected hit=%0b evicted=%0b key=%h occ=%0d",
							want.hit, want.evicted, want.evicted_key, want.occupancy);
						$display("  got hit=%0b evicted=%0b key=%h occ=%0d",
							rsp_ch.hit, rsp_ch.evicted, rsp_ch.evicted_key,
							rsp_ch.occupancy);
					end
				end
			end
		end
		if (req_taken)
			pending_responses = {pending_responses, lru_lookup(req_ch.request_key)};
	end

	initial begin
		key_t pool[8];
		int pool_size;
		int run_len;
		req_ch.valid = 1'b0;
		req_ch.request_key = '0;
		rsp_ch.ready = 1'b0;
		held_count = 0;
		mismatches = 0;

		// fill to capacity with the extreme keys, then hit the first, third and last positions
		queue_request(32'h0000_0000);
		queue_request(32'hFFFF_FFFF);
		queue_request(32'h8000_0000);
		queue_request(32'h7FFF_FFFF);
		queue_request(32'h0000_0000);
		queue_request(32'h8000_0000);
		queue_request(32'h8000_0000);
		queue_request(32'hFFFF_FFFF);
		queue_request(32'h0000_0000);
		// misses on a full store, mixed with hits
		queue_request(32'h5555_5555);
		queue_request(32'hAAAA_AAAA);
		queue_request(32'h0000_0001);
		queue_request(32'h8000_0001);
		queue_request(32'h0000_0001);
		queue_request(32'hAAAA_AAAA);
		queue_request(32'h5555_5555);
		queue_request(32'h8000_0001);
		queue_request(32'hFFFF_FFFE);
		queue_request(32'h7FFF_FFFF);
		queue_request(32'h5555_5555);

		while (requests_to_send.size() < 1120) begin
			pool_size = $urandom_range(1, 8);
			for (int i = 0; i < pool_size; i++) begin
				if (i > 0 && $urandom_range(0, 3) == 0)
					pool[i] = pool[i-1] ^ (key_t'(1) << $urandom_range(0, 31));
				else
					pool[i] = key_t'($urandom());
			end
			run_len = $urandom_range(10, 60);
			for (int n = 0; n < run_len; n++) begin
				if ($urandom_range(0, 11) == 0)
					queue_request(key_t'($urandom()));
				else
					queue_request(pool[$urandom_range(0, pool_size - 1)]);
			end
		end

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (requests_to_send.size() != 0 || req_ch.valid ||
			pending_responses.size() != 0);
		repeat (10) @(posedge clk);
		#1;

		if (mismatches == 0 && pending_responses.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
